// ===== hw/rtl/stt_pkg.sv =====
// Shared types, token class codes and keyword/datatype tables of the tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    // Token class codes
    localparam logic [3:0] CLS_KEYWORD    = 4'd0;
    localparam logic [3:0] CLS_DATATYPE   = 4'd1;
    localparam logic [3:0] CLS_ENDCOMMAND = 4'd2;
    localparam logic [3:0] CLS_LITERAL    = 4'd3;
    localparam logic [3:0] CLS_OPENBLOCK  = 4'd4;
    localparam logic [3:0] CLS_CLOSEBLOCK = 4'd5;
    localparam logic [3:0] CLS_OPENPAREN  = 4'd6;
    localparam logic [3:0] CLS_CLOSEPAREN = 4'd7;
    localparam logic [3:0] CLS_IDENTIFIER = 4'd8;

    // Character codes
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;

    // Saturation limits
    localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;
    localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;

    // Table words: three keywords then four datatypes
    localparam int NUM_WORDS = 7;
    localparam int NUM_KEYWORDS = 3;
    localparam logic [2:0] WORD_LEN [NUM_WORDS] =
        '{3'd3, 3'd3, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
    localparam logic [7:0] WORD_CHAR [NUM_WORDS][8] = '{
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
        '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Output queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  token_class;
        logic [1:0]  word_index;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [23:0] line_number;
        logic        last_of_run;
    } token_t;

    // Up to two tokens from one request
    typedef struct packed {
        logic   push0;
        logic   push1;
        token_t tok0;
        token_t tok1;
    } push_t;

endpackage

// ===== hw/rtl/stt_text_if.sv =====
// Request channel carrying one text byte per request.
`timescale 1ns / 1ps

interface stt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== hw/rtl/stt_token_if.sv =====
// Request channel carrying one token per request.
`timescale 1ns / 1ps

interface stt_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_class;
    logic [1:0]  word_index;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic        last_of_run;

    modport source (output valid, output token_class, output word_index,
                    output start_offset, output token_length, output line_number,
                    output last_of_run, input ready);
    modport sink (input valid, input token_class, input word_index,
                  input start_offset, input token_length, input line_number,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/stt_scan.sv =====
// Scanner state and per-byte token generation.
`timescale 1ns / 1ps

module stt_scan (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    output stt_pkg::push_t push
);

    logic                              str_reg, str_next;
    logic                              cmt_reg, cmt_next;
    logic [15:0]                       len_reg, len_next;
    logic [31:0]                       start_reg, start_next;
    logic                              lit_reg, lit_next;
    logic [stt_pkg::NUM_WORDS-1:0]     cand_reg, cand_next;
    logic [31:0]                       pos_reg, pos_next;
    logic [23:0]                       line_reg, line_next;

    logic                              plain;
    logic                              is_ws;
    logic                              is_nl;
    logic                              is_sym;
    logic [3:0]                        sym_class;
    logic                              flush;
    stt_pkg::token_t                   word_tok;
    stt_pkg::token_t                   sym_tok;

    // Symbol decode
    always_comb
    begin
        unique case (text_byte)
            stt_pkg::CH_SEMI:   sym_class = stt_pkg::CLS_ENDCOMMAND;
            stt_pkg::CH_LBRACE: sym_class = stt_pkg::CLS_OPENBLOCK;
            stt_pkg::CH_RBRACE: sym_class = stt_pkg::CLS_CLOSEBLOCK;
            stt_pkg::CH_LPAREN: sym_class = stt_pkg::CLS_OPENPAREN;
            stt_pkg::CH_RPAREN: sym_class = stt_pkg::CLS_CLOSEPAREN;
            default:            sym_class = stt_pkg::CLS_IDENTIFIER;
        endcase
    end

    assign plain  = !str_reg && !cmt_reg;
    assign is_ws  = plain && (text_byte == stt_pkg::CH_SPACE || text_byte == stt_pkg::CH_TAB);
    assign is_nl  = plain && (text_byte == stt_pkg::CH_NEWLINE);
    assign is_sym = plain && (sym_class != stt_pkg::CLS_IDENTIFIER);
    assign flush  = (is_ws || is_nl || is_sym) && (len_reg != 16'd0);

    // Classify the pending word: first table hit wins, else literal or identifier
    always_comb
    begin
        logic found;
        found = 1'b0;
        word_tok.token_class = lit_reg ? stt_pkg::CLS_LITERAL : stt_pkg::CLS_IDENTIFIER;
        word_tok.word_index  = 2'd0;
        for (int i = 0; i < stt_pkg::NUM_WORDS; i++)
        begin
            if (!found && cand_reg[i] && len_reg == 16'(stt_pkg::WORD_LEN[i]))
            begin
                found = 1'b1;
                if (i < stt_pkg::NUM_KEYWORDS)
                begin
                    word_tok.token_class = stt_pkg::CLS_KEYWORD;
                    word_tok.word_index  = 2'(i);
                end
                else
                begin
                    word_tok.token_class = stt_pkg::CLS_DATATYPE;
                    word_tok.word_index  = 2'(i - stt_pkg::NUM_KEYWORDS);
                end
            end
        end
        word_tok.start_offset = start_reg;
        word_tok.token_length = len_reg;
        word_tok.line_number  = line_reg;
        word_tok.last_of_run  = !is_sym;
    end

    // Single-character symbol token
    always_comb
    begin
        sym_tok.token_class  = sym_class;
        sym_tok.word_index   = 2'd0;
        sym_tok.start_offset = pos_reg;
        sym_tok.token_length = 16'd1;
        sym_tok.line_number  = line_reg;
        sym_tok.last_of_run  = 1'b1;
    end

    // Result slots: word first, symbol after it
    always_comb
    begin
        push.push0 = accept && (flush || is_sym);
        push.push1 = accept && flush && is_sym;
        push.tok0  = flush ? word_tok : sym_tok;
        push.tok1  = sym_tok;
    end

    // Next state
    always_comb
    begin
        logic [stt_pkg::NUM_WORDS-1:0] cand_base;
        str_next   = str_reg;
        cmt_next   = cmt_reg;
        len_next   = len_reg;
        start_next = start_reg;
        lit_next   = lit_reg;
        cand_next  = cand_reg;
        line_next  = line_reg;
        pos_next   = (pos_reg != stt_pkg::POS_MAX) ? pos_reg + 32'd1 : pos_reg;
        cand_base  = (len_reg == 16'd0) ? '1 : cand_reg;

        priority if (is_ws || is_nl || is_sym)
        begin
            len_next   = 16'd0;
            start_next = 32'd0;
            lit_next   = 1'b0;
            cand_next  = '1;
            if (is_nl && line_reg != stt_pkg::LINE_MAX)
                line_next = line_reg + 24'd1;
        end
        else if (text_byte == stt_pkg::CH_BACKSLASH)
        begin
            cmt_next = !cmt_reg;
            // closing a comment drops the pending word
            if (cmt_reg)
            begin
                len_next   = 16'd0;
                start_next = 32'd0;
                lit_next   = 1'b0;
                cand_next  = '1;
            end
        end
        else
        begin
            if (len_reg == 16'd0)
            begin
                start_next = pos_reg;
                lit_next   = (text_byte >= stt_pkg::CH_ZERO && text_byte <= stt_pkg::CH_NINE)
                             || text_byte == stt_pkg::CH_MINUS
                             || text_byte == stt_pkg::CH_QUOTE;
            end
            for (int i = 0; i < stt_pkg::NUM_WORDS; i++)
                cand_next[i] = cand_base[i]
                               && (len_reg < 16'(stt_pkg::WORD_LEN[i]))
                               && (stt_pkg::WORD_CHAR[i][len_reg[2:0]] == text_byte);
            if (len_reg != stt_pkg::LEN_MAX)
                len_next = len_reg + 16'd1;
            if (text_byte == stt_pkg::CH_QUOTE && !cmt_reg)
                str_next = !str_reg;
        end

        // end of text returns everything to reset
        if (end_of_text)
        begin
            str_next   = 1'b0;
            cmt_next   = 1'b0;
            len_next   = 16'd0;
            start_next = 32'd0;
            lit_next   = 1'b0;
            cand_next  = '1;
            pos_next   = 32'd0;
            line_next  = 24'd0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            str_reg   <= 1'b0;
            cmt_reg   <= 1'b0;
            len_reg   <= 16'd0;
            start_reg <= 32'd0;
            lit_reg   <= 1'b0;
            cand_reg  <= '1;
            pos_reg   <= 32'd0;
            line_reg  <= 24'd0;
        end
        else if (accept)
        begin
            str_reg   <= str_next;
            cmt_reg   <= cmt_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            lit_reg   <= lit_next;
            cand_reg  <= cand_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ===== hw/rtl/stt_queue.sv =====
// Small token queue taking up to two tokens per cycle and giving out one per cycle while tokens.ready is high.
`timescale 1ns / 1ps

module stt_queue #(
    parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  stt_pkg::push_t push,
    output logic           room,
    stt_token_if.source    tokens
);

    localparam int PW = $clog2(DEPTH);

    stt_pkg::token_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW:0]     count_reg, count_next;
    logic            pop;
    logic [PW-1:0]   wr_plus1;
    stt_pkg::token_t head;

    assign room     = (count_reg <= (PW+1)'(DEPTH - 2));
    assign pop      = tokens.valid && tokens.ready;
    assign wr_plus1 = wr_reg + PW'(1);
    assign head     = entry_reg[rd_reg];

    // Pointers and fill count
    always_comb
    begin
        wr_next    = wr_reg + PW'(push.push0) + PW'(push.push1);
        rd_next    = rd_reg + PW'(pop);
        count_next = count_reg + (PW+1)'(push.push0) + (PW+1)'(push.push1)
                     - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.push0)
            entry_reg[wr_reg] <= push.tok0;
        if (push.push1)
            entry_reg[wr_plus1] <= push.tok1;
    end

    // Head of queue drives the output channel
    assign tokens.valid        = (count_reg != '0);
    assign tokens.token_class  = head.token_class;
    assign tokens.word_index   = head.word_index;
    assign tokens.start_offset = head.start_offset;
    assign tokens.token_length = head.token_length;
    assign tokens.line_number  = head.line_number;
    assign tokens.last_of_run  = head.last_of_run;

endmodule

// ===== hw/rtl/source_text_tokenizer_unit.sv =====
// Top level of the source text tokenizer.
//
//  channel  dir  payload                                        handshake
//  text     in   text_byte[7:0], end_of_text                    valid/ready
//  tokens   out  token_class[3:0], word_index[1:0],             valid/ready
//                start_offset[31:0], token_length[15:0],
//                line_number[23:0], last_of_run
//
// One byte per cycle is accepted while text.ready is high; scanner state updates in
// the accepting cycle. A byte gives zero, one or two tokens, pushed into a
// four-entry queue that drains one token per cycle while tokens.ready is high.
// text.ready is high while the queue has room for two tokens.
// Reset clears all scanner state and empties the queue.
`timescale 1ns / 1ps

module source_text_tokenizer_unit #(
    parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH
) (
    input logic         clk,
    input logic         rst_n,
    stt_text_if.sink    text,
    stt_token_if.source tokens
);

    stt_pkg::push_t push;
    logic           room;
    logic           accept;

    assign text.ready = room;
    assign accept     = text.valid && room;

    stt_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text.text_byte),
        .end_of_text (text.end_of_text),
        .push        (push)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .tokens (tokens)
    );

endmodule

// ===== sim/source_text_tokenizer_unit_tb.sv =====
// Self-checking testbench for the source text tokenizer: predicts tokens per accepted byte.
`timescale 1ns / 1ps

module source_text_tokenizer_unit_tb;

    import stt_pkg::*;

    localparam int          TEXT_ITEMS  = 1400;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          DRAIN_WAIT  = 20;

    // One pending text request
    typedef struct packed {
        logic [7:0] chr;
        logic       eot;
        logic       hold;
    } text_req_t;

    logic clk;
    logic rst_n;

    stt_text_if  text_ch ();
    stt_token_if tok_ch ();

    source_text_tokenizer_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (tok_ch)
    );

    text_req_t   text_queue [$];
    token_t      due_tokens [$];
    text_req_t   cur_req;
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    bit          text_took   = 1'b0;
    bit          hold_next   = 1'b0;
    bit          rand_eot    = 1'b0;

    // Scanner state mirrored for prediction
    logic        str_mode   = 1'b0;
    logic        cmt_mode   = 1'b0;
    logic [15:0] word_len   = '0;
    logic [31:0] word_start = '0;
    logic        word_lit   = 1'b0;
    logic [6:0]  word_cand  = '1;
    logic [31:0] scan_pos   = '0;
    logic [23:0] scan_line  = '0;

    string table_words [NUM_WORDS] = '{"var", "let", "if", "int", "float", "string", "bool"};
    string ident_chars = "abfgilnorstvx_";

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle stretches: no gaps or stalls for a quarter of the time
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cycle_count[8:7] == 2'd0)
            return 0;
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void clear_word();
        word_len   = '0;
        word_start = '0;
        word_lit   = 1'b0;
        word_cand  = '1;
    endfunction

    function automatic void add_token(logic [3:0] cls, logic [1:0] idx,
                                      logic [31:0] start, logic [15:0] len);
        token_t t;
        t.token_class  = cls;
        t.word_index   = idx;
        t.start_offset = start;
        t.token_length = len;
        t.line_number  = scan_line;
        t.last_of_run  = 1'b0;
        due_tokens.insert(due_tokens.size(), t);
    endfunction

    // Classify and emit the pending word, if any
    function automatic void flush_word();
        logic [3:0] cls;
        logic [1:0] idx;
        bit         hit;
        cls = CLS_IDENTIFIER;
        idx = '0;
        hit = 1'b0;
        if (word_len == 0)
            return;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (!hit && word_cand[i] && word_len == 16'(WORD_LEN[i]))
            begin
                hit = 1'b1;
                if (i < NUM_KEYWORDS)
                begin
                    cls = CLS_KEYWORD;
                    idx = 2'(i);
                end
                else
                begin
                    cls = CLS_DATATYPE;
                    idx = 2'(i - NUM_KEYWORDS);
                end
            end
        end
        if (!hit && word_lit)
            cls = CLS_LITERAL;
        add_token(cls, idx, word_start, word_len);
        clear_word();
    endfunction

    function automatic void append_char(logic [7:0] c);
        if (word_len == 0)
        begin
            word_start = scan_pos;
            word_lit   = (c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_QUOTE;
            word_cand  = '1;
        end
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (word_cand[i])
            begin
                if (word_len >= 16'(WORD_LEN[i]))
                    word_cand[i] = 1'b0;
                else if (WORD_CHAR[i][word_len[2:0]] != c)
                    word_cand[i] = 1'b0;
            end
        end
        if (word_len != LEN_MAX)
            word_len++;
    endfunction

    // Work out the tokens caused by one accepted text request
    function automatic void scan_char(logic [7:0] c, logic eot);
        logic       plain;
        logic       is_sym;
        logic [3:0] sym_cls;
        int         before_cnt;
        plain      = !str_mode && !cmt_mode;
        before_cnt = due_tokens.size();
        is_sym     = 1'b1;
        case (c)
            CH_SEMI:   sym_cls = CLS_ENDCOMMAND;
            CH_LBRACE: sym_cls = CLS_OPENBLOCK;
            CH_RBRACE: sym_cls = CLS_CLOSEBLOCK;
            CH_LPAREN: sym_cls = CLS_OPENPAREN;
            CH_RPAREN: sym_cls = CLS_CLOSEPAREN;
            default:
            begin
                sym_cls = CLS_IDENTIFIER;
                is_sym  = 1'b0;
            end
        endcase

        if ((c == CH_SPACE || c == CH_TAB) && plain)
            flush_word();
        else if ((c == CH_NEWLINE || is_sym) && plain)
        begin
            flush_word();
            if (c == CH_NEWLINE)
            begin
                if (scan_line != LINE_MAX)
                    scan_line++;
            end
            else
                add_token(sym_cls, 2'd0, scan_pos, 16'd1);
        end
        else if (c == CH_BACKSLASH)
        begin
            cmt_mode = !cmt_mode;
            // closing a comment throws the pending word away
            if (!cmt_mode)
                clear_word();
        end
        else
        begin
            append_char(c);
            if (c == CH_QUOTE && !cmt_mode)
                str_mode = !str_mode;
        end

        if (due_tokens.size() > before_cnt)
            due_tokens[due_tokens.size() - 1].last_of_run = 1'b1;
        if (scan_pos != POS_MAX)
            scan_pos++;
        if (eot)
        begin
            str_mode  = 1'b0;
            cmt_mode  = 1'b0;
            scan_pos  = '0;
            scan_line = '0;
            clear_word();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void check_token(token_t got);
        token_t want;
        if (due_tokens.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected token: cls=%0d idx=%0d start=%0d len=%0d line=%0d last=%0b",
                         $realtime, got.token_class, got.word_index, got.start_offset,
                         got.token_length, got.line_number, got.last_of_run);
            return;
        end
        want = due_tokens.pop_front();
        if (got.token_class !== want.token_class || got.word_index !== want.word_index ||
            got.start_offset !== want.start_offset || got.token_length !== want.token_length ||
            got.line_number !== want.line_number || got.last_of_run !== want.last_of_run)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("[%0t] token mismatch", $realtime);
                $display("  expected cls=%0d idx=%0d start=%0d len=%0d line=%0d last=%0b",
                         want.token_class, want.word_index, want.start_offset,
                         want.token_length, want.line_number, want.last_of_run);
                $display("  actual   cls=%0d idx=%0d start=%0d len=%0d line=%0d last=%0b",
                         got.token_class, got.word_index, got.start_offset,
                         got.token_length, got.line_number, got.last_of_run);
            end
        end
    endfunction

    // Monitor: predict on accepted text requests, check accepted tokens
    always @(posedge clk)
    begin
        token_t got;
        text_took = rst_n && text_ch.valid && text_ch.ready;
        if (text_took)
            scan_char(text_ch.text_byte, text_ch.end_of_text);
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            got.token_class  = tok_ch.token_class;
            got.word_index   = tok_ch.word_index;
            got.start_offset = tok_ch.start_offset;
            got.token_length = tok_ch.token_length;
            got.line_number  = tok_ch.line_number;
            got.last_of_run  = tok_ch.last_of_run;
            check_token(got);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL source_text_tokenizer_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver and token sink
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            text_ch.valid       <= 1'b0;
            text_ch.text_byte   <= '0;
            text_ch.end_of_text <= 1'b0;
        end
        else if (!text_ch.valid || text_took)
        begin
            if (gap_left > 0)
            begin
                text_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (text_queue.size() > 0 &&
                     !(text_queue[0].hold && due_tokens.size() != 0))
            begin
                cur_req = text_queue.pop_front();
                text_ch.valid       <= 1'b1;
                text_ch.text_byte   <= cur_req.chr;
                text_ch.end_of_text <= cur_req.eot;
                gap_left = pick_gap();
            end
            else
                text_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            tok_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            tok_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_chr(logic [7:0] c, logic eot);
        text_req_t r;
        r.chr  = c;
        r.eot  = eot;
        r.hold = hold_next;
        hold_next = 1'b0;
        text_queue.insert(text_queue.size(), r);
    endtask

    // In the random part, end of text falls now and then on any byte of the string
    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
            push_chr(s[i], rand_eot && $urandom_range(0, 79) == 0);
    endtask

    task automatic push_ident(int unsigned n);
        for (int i = 0; i < n; i++)
            push_str(string'(ident_chars[$urandom_range(0, ident_chars.len() - 1)]));
    endtask

    task automatic push_symbol();
        logic [7:0] syms [5];
        syms = '{CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN};
        push_chr(syms[$urandom_range(0, 4)], rand_eot && $urandom_range(0, 79) == 0);
    endtask

    // Assorted bytes as found inside strings and comments
    task automatic push_body(int unsigned n);
        logic [7:0] c;
        int unsigned r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0: c = CH_SPACE;
                1: c = CH_NEWLINE;
                2: c = CH_SEMI;
                3: c = CH_LPAREN;
                4: c = 8'($urandom_range(0, 255));
                default: c = ident_chars[$urandom_range(0, ident_chars.len() - 1)];
            endcase
            push_chr(c, 1'b0);
        end
    endtask

    task automatic push_fragment();
        int unsigned r;
        string       w;
        r = $urandom_range(0, 99);
        if (r < 8)
            push_chr(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (r < 30)
            push_str(table_words[$urandom_range(0, NUM_WORDS - 1)]);
        else if (r < 44)
            push_ident($urandom_range(1, 9));
        else if (r < 54)
        begin
            if ($urandom_range(0, 2) == 0)
                push_chr(CH_MINUS, 1'b0);
            for (int i = $urandom_range(1, 5); i > 0; i--)
                push_chr(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end
        else if (r < 61)
        begin
            push_chr(CH_QUOTE, 1'b0);
            push_body($urandom_range(0, 6));
            push_chr(CH_QUOTE, 1'b0);
        end
        else if (r < 72)
            push_symbol();
        else if (r < 84)
            push_chr($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
        else if (r < 89)
            push_chr(CH_NEWLINE, 1'b0);
        else if (r < 94)
        begin
            push_chr(CH_BACKSLASH, 1'b0);
            push_body($urandom_range(0, 6));
            push_chr(CH_BACKSLASH, 1'b0);
        end
        else
        begin
            // table word with one character altered or one added
            w = table_words[$urandom_range(0, NUM_WORDS - 1)];
            if ($urandom_range(0, 1))
                w[$urandom_range(0, w.len() - 1)] =
                    ident_chars[$urandom_range(0, ident_chars.len() - 1)];
            else
                w = {w, "s"};
            push_str(w);
        end
    endtask

    initial
    begin
        int sent;
        rst_n = 1'b0;

        // Directed text: every class, symbol splits, literals, comment discard,
        // extreme bytes, long word, newline counting, word flushed by the byte that ends the text
        push_str("if(9)");
        push_str("{-x;}");
        push_str("\\ab\\");
        push_chr(8'h00, 1'b0);
        push_chr(8'hFF, 1'b0);
        push_str(" stringy\n");
        push_str("int");
        push_chr(CH_SPACE, 1'b0);
        push_str("bool");
        push_chr(CH_TAB, 1'b1);

        // Random text, mostly well-formed fragments
        rand_eot = 1'b1;
        sent     = text_queue.size();
        while (text_queue.size() < TEXT_ITEMS)
        begin
            if (sent < TEXT_ITEMS / 2 && text_queue.size() >= TEXT_ITEMS / 2)
                hold_next = 1'b1;
            sent = text_queue.size();
            push_fragment();
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_queue.size() != 0 || text_ch.valid)
            @(posedge clk);
        while (due_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && due_tokens.size() == 0)
            $display("PASS source_text_tokenizer_unit");
        else
            $display("FAIL source_text_tokenizer_unit");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/stt_pkg.sv
hw/rtl/stt_text_if.sv
hw/rtl/stt_token_if.sv
hw/rtl/stt_scan.sv
hw/rtl/stt_queue.sv
hw/rtl/source_text_tokenizer_unit.sv
sim/source_text_tokenizer_unit_tb.sv
